>>> rtl/core/rbes_pkg.sv
// shared types, constants and fixed-point helpers for the euler step block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rbes_pkg;

    localparam int unsigned FRAC_BITS        = 16;
    localparam int unsigned ANG_FRAC         = 24;
    localparam int unsigned GUARD_SH         = 14;
    localparam int unsigned CORDIC_STEPS_DEF = 16;
    localparam int unsigned CORDIC_MAX_STEPS = 24;
    localparam int unsigned GAIN_SH          = 30;
    localparam logic [30:0] CORDIC_GAIN_Q30  = 31'd652032874;

    // 360 degrees in the step angle format, and the number of restoring steps
    // that bring a rounded step angle below it
    localparam longint      FULL_QF   = longint'(360) << FRAC_BITS;
    localparam int unsigned MOD_STEPS = 9;

    // heading clamp: +-min(1.0, 131071)
    localparam longint HEAD_LIM = ((longint'(1) << FRAC_BITS) < 131071) ?
                                  (longint'(1) << FRAC_BITS) : 131071;

    // quotient width of the angular acceleration divide
    localparam int unsigned DIV_W = 32 + FRAC_BITS;

    localparam logic [29:0] ATAN_Q24 [CORDIC_MAX_STEPS] = '{
        30'd754974720, 30'd445687602, 30'd235489089, 30'd119537938,
        30'd60000935,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234684,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115
    };

    typedef enum logic [2:0] {
        CFG_TIME_STEP = 3'd0,
        CFG_GRAVITY_X = 3'd1,
        CFG_GRAVITY_Y = 3'd2,
        CFG_FORCE_X   = 3'd3,
        CFG_FORCE_Y   = 3'd4
    } t_cfg_idx;

    // one item as it travels down the pipeline, with scratch for products
    typedef struct packed {
        logic               is_body;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] w;
        logic signed [31:0] w0;
        logic signed [17:0] hx;
        logic signed [17:0] hy;
        logic        [30:0] mass;
        logic        [30:0] ex;
        logic        [30:0] ey;
        logic        [30:0] iner;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] tq;
        logic signed [31:0] alpha;
        logic signed [63:0] p0;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [63:0] p3;
        logic signed [17:0] nhx;
        logic signed [17:0] nhy;
        logic               f_lin;
        logic               f_body;
    } t_item;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX) return 32'sh7fffffff;
        if (v < S32_MIN) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > S32_MAX) || (v < S32_MIN);
    endfunction

    // shift right with rounding to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input int unsigned s);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rbes_div.sv
// pipelined restoring divider, one quotient bit per stage, item rides along
// depends on rbes_pkg
`timescale 1ns / 1ps
`default_nettype none

module rbes_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_vld,
    input  wire rbes_pkg::t_item             i_item,
    output logic                             o_vld,
    output rbes_pkg::t_item                  o_item,
    output logic [rbes_pkg::DIV_W-1:0]       o_quot
);

    localparam int unsigned NB = rbes_pkg::DIV_W;

    logic                r_vld  [NB];
    rbes_pkg::t_item     r_item [NB];
    logic [31:0]         r_rem  [NB];
    logic [NB-1:0]       r_nq   [NB];

    logic [NB-1:0]       n_nq   [NB];
    logic [31:0]         n_rem  [NB];

    for (genvar j = 0; j < NB; j++) begin : g_stage
        logic            in_vld;
        rbes_pkg::t_item in_item;
        logic [31:0]     in_rem;
        logic [NB-1:0]   in_nq;

        if (j == 0) begin : g_head
            // magnitude of torque, scaled up by the fraction
            logic [31:0] mag;
            assign mag     = i_item.tq[31] ? (~i_item.tq + 32'd1) : i_item.tq;
            assign in_vld  = i_vld;
            assign in_item = i_item;
            assign in_rem  = '0;
            assign in_nq   = {mag, {rbes_pkg::FRAC_BITS{1'b0}}};
        end else begin : g_tail
            assign in_vld  = r_vld[j-1];
            assign in_item = r_item[j-1];
            assign in_rem  = r_rem[j-1];
            assign in_nq   = r_nq[j-1];
        end

        always_comb begin
            logic [31:0]    trial;
            logic           bitq;
            trial = {in_rem[30:0], in_nq[NB-1]};
            bitq  = (trial >= {1'b0, in_item.iner});
            n_rem[j] = bitq ? (trial - {1'b0, in_item.iner}) : trial;
            n_nq[j]  = {in_nq[NB-2:0], bitq};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= in_vld;
            end
            if (i_en) begin
                r_item[j] <= in_item;
                r_rem[j]  <= n_rem[j];
                r_nq[j]   <= n_nq[j];
            end
        end
    end

    assign o_vld  = r_vld[NB-1];
    assign o_item = r_item[NB-1];
    assign o_quot = r_nq[NB-1];

endmodule

`default_nettype wire

>>> rtl/core/rbes_cordic.sv
// pipelined heading rotation: angle rounding, modulo 360, fold, cordic, gain, clamp
// depends on rbes_pkg
`timescale 1ns / 1ps
`default_nettype none

module rbes_cordic #(
    parameter int unsigned CORDIC_STEPS = rbes_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_vld,
    input  wire rbes_pkg::t_item i_item,
    output logic                 o_vld,
    output rbes_pkg::t_item      o_item
);

    localparam int unsigned N = (CORDIC_STEPS > rbes_pkg::CORDIC_MAX_STEPS) ?
                                rbes_pkg::CORDIC_MAX_STEPS : CORDIC_STEPS;
    localparam int unsigned MOD0  = 1;
    localparam int unsigned WRAP  = MOD0 + rbes_pkg::MOD_STEPS;
    localparam int unsigned FOLD  = WRAP + 1;
    localparam int unsigned ROT0  = FOLD + 1;
    localparam int unsigned GAINS = ROT0 + N;
    localparam int unsigned LAST  = GAINS + 1;
    localparam int unsigned NST   = LAST + 1;

    localparam logic signed [34:0] D90  = 35'(90)  <<< rbes_pkg::ANG_FRAC;
    localparam logic signed [34:0] D180 = 35'(180) <<< rbes_pkg::ANG_FRAC;
    localparam logic signed [34:0] D360 = 35'(360) <<< rbes_pkg::ANG_FRAC;
    localparam logic signed [63:0] LIM  = 64'(rbes_pkg::HEAD_LIM);

    typedef struct packed {
        rbes_pkg::t_item    item;
        logic               neg;
        logic signed [34:0] acc;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [64:0] gx;
        logic signed [64:0] gy;
    } t_cstate;

    logic     r_vld [NST];
    t_cstate  r_st  [NST];
    t_cstate  n_st  [NST];

    for (genvar s = 0; s < NST; s++) begin : g_stage
        logic in_vld;

        if (s == 0) begin : g_vin
            assign in_vld = i_vld;
        end else begin : g_vchain
            assign in_vld = r_vld[s-1];
        end

        if (s == 0) begin : g_round
            always_comb begin
                logic signed [63:0] ang;
                ang        = rbes_pkg::rnd_shr(i_item.p0, rbes_pkg::FRAC_BITS);
                n_st[s]    = '0;
                n_st[s].item = i_item;
                n_st[s].neg  = ang[63];
                n_st[s].acc  = ang[63] ? 35'(-ang) : 35'(ang);
            end
        end else if (s < WRAP) begin : g_mod
            // restoring remainder by 360 degrees, high multiple first
            localparam logic signed [34:0] SUB_V =
                35'(rbes_pkg::FULL_QF) <<< (rbes_pkg::MOD_STEPS - s);
            always_comb begin
                n_st[s] = r_st[s-1];
                if (r_st[s-1].acc >= SUB_V) n_st[s].acc = r_st[s-1].acc - SUB_V;
            end
        end else if (s == WRAP) begin : g_wrap
            always_comb begin
                logic signed [34:0] a;
                a = r_st[s-1].neg ? -r_st[s-1].acc : r_st[s-1].acc;
                a = a <<< (rbes_pkg::ANG_FRAC - rbes_pkg::FRAC_BITS);
                if (a >= D180) a = a - D360;
                else if (a < -D180) a = a + D360;
                n_st[s]     = r_st[s-1];
                n_st[s].acc = a;
            end
        end else if (s == FOLD) begin : g_fold
            always_comb begin
                logic signed [33:0] x0;
                logic signed [33:0] y0;
                x0      = 34'(r_st[s-1].item.hx) <<< rbes_pkg::GUARD_SH;
                y0      = 34'(r_st[s-1].item.hy) <<< rbes_pkg::GUARD_SH;
                n_st[s] = r_st[s-1];
                n_st[s].x = x0;
                n_st[s].y = y0;
                // outside +-90: turn the vector half way round first
                if (r_st[s-1].acc > D90) begin
                    n_st[s].x   = -x0;
                    n_st[s].y   = -y0;
                    n_st[s].acc = r_st[s-1].acc - D180;
                end else if (r_st[s-1].acc < -D90) begin
                    n_st[s].x   = -x0;
                    n_st[s].y   = -y0;
                    n_st[s].acc = r_st[s-1].acc + D180;
                end
            end
        end else if (s < GAINS) begin : g_rot
            localparam int unsigned I = s - ROT0;
            localparam logic signed [34:0] ATV = 35'(rbes_pkg::ATAN_Q24[I]);
            always_comb begin
                logic signed [33:0] xs;
                logic signed [33:0] ys;
                xs      = r_st[s-1].x >>> I;
                ys      = r_st[s-1].y >>> I;
                n_st[s] = r_st[s-1];
                if (!r_st[s-1].acc[34]) begin
                    n_st[s].x   = r_st[s-1].x - ys;
                    n_st[s].y   = r_st[s-1].y + xs;
                    n_st[s].acc = r_st[s-1].acc - ATV;
                end else begin
                    n_st[s].x   = r_st[s-1].x + ys;
                    n_st[s].y   = r_st[s-1].y - xs;
                    n_st[s].acc = r_st[s-1].acc + ATV;
                end
            end
        end else if (s == GAINS) begin : g_gain
            always_comb begin
                n_st[s]    = r_st[s-1];
                n_st[s].gx = r_st[s-1].x * $signed({1'b0, rbes_pkg::CORDIC_GAIN_Q30});
                n_st[s].gy = r_st[s-1].y * $signed({1'b0, rbes_pkg::CORDIC_GAIN_Q30});
            end
        end else begin : g_clamp
            always_comb begin
                logic signed [63:0] vx;
                logic signed [63:0] vy;
                logic               f;
                vx = rbes_pkg::rnd_shr(64'(r_st[s-1].gx),
                                       rbes_pkg::GUARD_SH + rbes_pkg::GAIN_SH);
                vy = rbes_pkg::rnd_shr(64'(r_st[s-1].gy),
                                       rbes_pkg::GUARD_SH + rbes_pkg::GAIN_SH);
                f  = (vx > LIM) || (vx < -LIM) || (vy > LIM) || (vy < -LIM);
                if (vx > LIM) vx = LIM;
                if (vx < -LIM) vx = -LIM;
                if (vy > LIM) vy = LIM;
                if (vy < -LIM) vy = -LIM;
                n_st[s] = r_st[s-1];
                n_st[s].item.nhx    = 18'(vx);
                n_st[s].item.nhy    = 18'(vy);
                n_st[s].item.f_body = r_st[s-1].item.f_body | f;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= in_vld;
            end
            if (i_en) r_st[s] <= n_st[s];
        end
    end

    assign o_vld  = r_vld[NST-1];
    assign o_item = r_st[NST-1].item;

endmodule

`default_nettype wire

>>> rtl/core/rigid_body_euler_step.sv
// top level of the semi-implicit euler step for 2-d particles and bodies
// depends on rbes_pkg, rbes_div and rbes_cordic
//
// usage
//   configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//     (0 time_step, 1 gravity_x, 2 gravity_y, 3 applied_force_x,
//     4 applied_force_y); write only while the pipeline is empty
//   input stream: one particle or body state per beat on i_s_axis_*,
//     tuser carries is_body
//   output stream: one advanced state per beat on o_m_axis_*,
//     tuser carries the saturated flag
//   throughput: one beat per cycle, every stage is a register stage
//   latency: 72 + CORDIC_STEPS cycles, steps capped at 24 (88 by default),
//     set by the one-bit-per-stage angular divide and the cordic chain
//   reset: empties the pipeline and loads the register defaults
//     (time_step 1092, all others 0)
//   stall: when the output beat waits, the whole pipeline holds and
//     o_s_axis_tready drops, so nothing is lost or repeated
`timescale 1ns / 1ps
`default_nettype none

module rigid_body_euler_step #(
    parameter int unsigned CORDIC_STEPS = rbes_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // configuration write port
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data,
    // input beats
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // pos_x, pos_y, vel_x, vel_y, spin_rate, heading_x, heading_y,
    // body_mass, extent_x, extent_y, inertia
    input  wire logic [319:0] i_s_axis_tdata,
    // is_body
    input  wire logic [0:0]   i_s_axis_tuser,
    // output beats
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_spin_rate,
    // new_heading_x, new_heading_y, torque_out, zero pad
    output logic [231:0]      o_m_axis_tdata,
    // saturated
    output logic [0:0]        o_m_axis_tuser
);

    localparam int unsigned FB = rbes_pkg::FRAC_BITS;

    // configuration registers
    logic        [16:0] r_dt;
    logic signed [31:0] r_gx;
    logic signed [31:0] r_gy;
    logic signed [31:0] r_fx;
    logic signed [31:0] r_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= 17'd1092;
            r_gx <= '0;
            r_gy <= '0;
            r_fx <= '0;
            r_fy <= '0;
        end else if (i_cfg_we) begin
            unique case (rbes_pkg::t_cfg_idx'(i_cfg_idx))
                rbes_pkg::CFG_TIME_STEP: r_dt <= i_cfg_data[16:0];
                rbes_pkg::CFG_GRAVITY_X: r_gx <= i_cfg_data;
                rbes_pkg::CFG_GRAVITY_Y: r_gy <= i_cfg_data;
                rbes_pkg::CFG_FORCE_X:   r_fx <= i_cfg_data;
                rbes_pkg::CFG_FORCE_Y:   r_fy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [17:0] dt_s;
    assign dt_s = $signed({1'b0, r_dt});

    // whole pipeline moves together; it holds only when the output beat waits
    logic r_out_vld;
    logic en;
    assign en = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = en;

    rbes_pkg::t_item n_s1, r_s1, n_s2, r_s2, n_s3, r_s3, n_s4, r_s4, n_s5, r_s5;
    rbes_pkg::t_item n_s6, r_s6, n_s7, r_s7, n_s8, r_s8, n_s9, r_s9;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9;

    // stage 1: unpack, acceleration with y negated
    always_comb begin
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        sx = 64'(r_gx) + 64'(r_fx);
        sy = -64'(r_gy) - 64'(r_fy);
        n_s1         = '0;
        n_s1.is_body = i_s_axis_tuser[0];
        n_s1.px      = i_s_axis_tdata[31:0];
        n_s1.py      = i_s_axis_tdata[63:32];
        n_s1.vx      = i_s_axis_tdata[95:64];
        n_s1.vy      = i_s_axis_tdata[127:96];
        n_s1.w       = i_s_axis_tdata[159:128];
        n_s1.w0      = i_s_axis_tdata[159:128];
        n_s1.hx      = i_s_axis_tdata[177:160];
        n_s1.hy      = i_s_axis_tdata[195:178];
        n_s1.mass    = i_s_axis_tdata[226:196];
        n_s1.ex      = i_s_axis_tdata[257:227];
        n_s1.ey      = i_s_axis_tdata[288:258];
        n_s1.iner    = i_s_axis_tdata[319:289];
        n_s1.ax      = rbes_pkg::sat32(sx);
        n_s1.ay      = rbes_pkg::sat32(sy);
        n_s1.f_lin   = rbes_pkg::ovf32(sx) | rbes_pkg::ovf32(sy);
    end

    // stage 2: velocity increments and body force products
    always_comb begin
        logic signed [49:0] m0;
        logic signed [49:0] m1;
        n_s2    = r_s1;
        m0      = r_s1.ax * dt_s;
        m1      = r_s1.ay * dt_s;
        n_s2.p0 = 64'(m0);
        n_s2.p1 = 64'(m1);
        n_s2.p2 = $signed({1'b0, r_s1.mass}) * r_s1.ax;
        n_s2.p3 = $signed({1'b0, r_s1.mass}) * r_s1.ay;
    end

    // stage 3: new velocity, force
    always_comb begin
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        logic signed [63:0] fx;
        logic signed [63:0] fy;
        vx = 64'(r_s2.vx) + rbes_pkg::rnd_shr(r_s2.p0, FB);
        vy = 64'(r_s2.vy) + rbes_pkg::rnd_shr(r_s2.p1, FB);
        fx = rbes_pkg::rnd_shr(r_s2.p2, FB);
        fy = rbes_pkg::rnd_shr(r_s2.p3, FB);
        n_s3        = r_s2;
        n_s3.vx     = rbes_pkg::sat32(vx);
        n_s3.vy     = rbes_pkg::sat32(vy);
        n_s3.fx     = rbes_pkg::sat32(fx);
        n_s3.fy     = rbes_pkg::sat32(fy);
        n_s3.f_lin  = r_s2.f_lin | rbes_pkg::ovf32(vx) | rbes_pkg::ovf32(vy);
        n_s3.f_body = r_s2.f_body | rbes_pkg::ovf32(fx) | rbes_pkg::ovf32(fy);
    end

    // stage 4: position increments and lever arm products (half extent)
    always_comb begin
        logic signed [49:0] m0;
        logic signed [49:0] m1;
        n_s4    = r_s3;
        m0      = r_s3.vx * dt_s;
        m1      = r_s3.vy * dt_s;
        n_s4.p0 = 64'(m0);
        n_s4.p1 = 64'(m1);
        n_s4.p2 = $signed({2'b00, r_s3.ex[30:1]}) * r_s3.fy;
        n_s4.p3 = $signed({2'b00, r_s3.ey[30:1]}) * r_s3.fx;
    end

    // stage 5: new position, torque
    always_comb begin
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic signed [63:0] tq;
        px = 64'(r_s4.px) + rbes_pkg::rnd_shr(r_s4.p0, FB);
        py = 64'(r_s4.py) + rbes_pkg::rnd_shr(r_s4.p1, FB);
        tq = rbes_pkg::rnd_shr(r_s4.p2 - r_s4.p3, FB);
        n_s5        = r_s4;
        n_s5.px     = rbes_pkg::sat32(px);
        n_s5.py     = rbes_pkg::sat32(py);
        n_s5.tq     = rbes_pkg::sat32(tq);
        n_s5.f_lin  = r_s4.f_lin | rbes_pkg::ovf32(px) | rbes_pkg::ovf32(py);
        n_s5.f_body = r_s4.f_body | rbes_pkg::ovf32(tq);
    end

    // angular acceleration: |torque| << frac over inertia
    logic                          div_vld;
    rbes_pkg::t_item               div_item;
    logic [rbes_pkg::DIV_W-1:0]    div_quot;

    rbes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v5),
        .i_item  (r_s5),
        .o_vld   (div_vld),
        .o_item  (div_item),
        .o_quot  (div_quot)
    );

    // stage 6: signed alpha, zero inertia gives zero with no flag
    always_comb begin
        logic [63:0]        q64;
        logic signed [63:0] qs;
        q64 = 64'(div_quot);
        qs  = div_item.tq[31] ? -$signed(q64) : $signed(q64);
        n_s6 = div_item;
        if (div_item.iner == '0) begin
            n_s6.alpha = '0;
        end else begin
            n_s6.alpha  = rbes_pkg::sat32(qs);
            n_s6.f_body = div_item.f_body | rbes_pkg::ovf32(qs);
        end
    end

    // stage 7: alpha * dt
    always_comb begin
        logic signed [49:0] m0;
        n_s7    = r_s6;
        m0      = r_s6.alpha * dt_s;
        n_s7.p0 = 64'(m0);
    end

    // stage 8: new spin rate
    always_comb begin
        logic signed [63:0] w;
        w = 64'(r_s7.w) + rbes_pkg::rnd_shr(r_s7.p0, FB);
        n_s8        = r_s7;
        n_s8.w      = rbes_pkg::sat32(w);
        n_s8.f_body = r_s7.f_body | rbes_pkg::ovf32(w);
    end

    // stage 9: step angle product, spin * dt
    always_comb begin
        logic signed [49:0] m0;
        n_s9    = r_s8;
        m0      = r_s8.w * dt_s;
        n_s9.p0 = 64'(m0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= div_vld;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
            r_v9 <= r_v8;
        end
        if (en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
            r_s6 <= n_s6;
            r_s7 <= n_s7;
            r_s8 <= n_s8;
            r_s9 <= n_s9;
        end
    end

    // heading rotation by the step angle in degrees
    logic            rot_vld;
    rbes_pkg::t_item rot_item;

    rbes_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v9),
        .i_item  (r_s9),
        .o_vld   (rot_vld),
        .o_item  (rot_item)
    );

    // output register: particles pass spin and heading through, torque zero
    logic [231:0] n_tdata;
    logic [231:0] r_tdata;
    logic         n_sat;
    logic         r_sat;

    always_comb begin
        logic               b;
        logic signed [31:0] w;
        logic signed [17:0] hx;
        logic signed [17:0] hy;
        logic signed [31:0] tq;
        b  = rot_item.is_body;
        w  = b ? rot_item.w   : rot_item.w0;
        hx = b ? rot_item.nhx : rot_item.hx;
        hy = b ? rot_item.nhy : rot_item.hy;
        tq = b ? rot_item.tq  : 32'sd0;
        n_tdata = {4'b0000, tq, hy, hx, w, rot_item.vy, rot_item.vx,
                   rot_item.py, rot_item.px};
        n_sat   = rot_item.f_lin | (b & rot_item.f_body);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= rot_vld;
        end
        if (en) begin
            r_tdata <= n_tdata;
            r_sat   <= n_sat;
        end
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = r_tdata;
    assign o_m_axis_tuser[0] = r_sat;

endmodule

`default_nettype wire
